### hdl/ucc_pkg.sv
// ucc_pkg: shared types and constant rule/exception tables of the UTF-16 case converter.
// No dependencies. Used by ucc_if.sv, ucc_mapper.sv and utf16_case_converter.sv.
package ucc_pkg;

  typedef logic [15:0] ucc_code_t;

  typedef enum logic [1:0] {
    PAR_ANY,
    PAR_EVEN,
    PAR_ODD
  } ucc_par_e;

  typedef struct packed {
    ucc_code_t lo;
    ucc_code_t hi;
    ucc_code_t add;
    ucc_par_e  par;
  } ucc_rule_t;

  typedef struct packed {
    ucc_code_t src;
    ucc_code_t dst;
  } ucc_pair_t;

  localparam int UpRuleCnt = 42;
  localparam int LoRuleCnt = 44;
  localparam int UpMapCnt  = 83;
  localparam int LoMapCnt  = 70;

  // add is taken modulo 2^16: 65535 is -1, 65528 is -8, and so on
  localparam ucc_rule_t UpRules [UpRuleCnt] = '{
    '{16'd97,    16'd122,   16'd65504, PAR_ANY},
    '{16'd224,   16'd246,   16'd65504, PAR_ANY},
    '{16'd248,   16'd254,   16'd65504, PAR_ANY},
    '{16'd941,   16'd943,   16'd65499, PAR_ANY},
    '{16'd945,   16'd961,   16'd65504, PAR_ANY},
    '{16'd963,   16'd971,   16'd65504, PAR_ANY},
    '{16'd1072,  16'd1103,  16'd65504, PAR_ANY},
    '{16'd1104,  16'd1119,  16'd65456, PAR_ANY},
    '{16'd1377,  16'd1414,  16'd65488, PAR_ANY},
    '{16'd7936,  16'd7943,  16'd8,     PAR_ANY},
    '{16'd7952,  16'd7957,  16'd8,     PAR_ANY},
    '{16'd7968,  16'd7975,  16'd8,     PAR_ANY},
    '{16'd7984,  16'd7991,  16'd8,     PAR_ANY},
    '{16'd8000,  16'd8005,  16'd8,     PAR_ANY},
    '{16'd8032,  16'd8039,  16'd8,     PAR_ANY},
    '{16'd8050,  16'd8053,  16'd86,    PAR_ANY},
    '{16'd8064,  16'd8071,  16'd8,     PAR_ANY},
    '{16'd8080,  16'd8087,  16'd8,     PAR_ANY},
    '{16'd8096,  16'd8103,  16'd8,     PAR_ANY},
    '{16'd8560,  16'd8575,  16'd65520, PAR_ANY},
    '{16'd9424,  16'd9449,  16'd65510, PAR_ANY},
    '{16'd65345, 16'd65370, 16'd65504, PAR_ANY},
    '{16'd314,   16'd328,   16'd65535, PAR_EVEN},
    '{16'd378,   16'd382,   16'd65535, PAR_EVEN},
    '{16'd436,   16'd438,   16'd65535, PAR_EVEN},
    '{16'd462,   16'd476,   16'd65535, PAR_EVEN},
    '{16'd1218,  16'd1220,  16'd65535, PAR_EVEN},
    '{16'd257,   16'd303,   16'd65535, PAR_ODD},
    '{16'd307,   16'd311,   16'd65535, PAR_ODD},
    '{16'd331,   16'd375,   16'd65535, PAR_ODD},
    '{16'd387,   16'd389,   16'd65535, PAR_ODD},
    '{16'd417,   16'd421,   16'd65535, PAR_ODD},
    '{16'd479,   16'd495,   16'd65535, PAR_ODD},
    '{16'd505,   16'd543,   16'd65535, PAR_ODD},
    '{16'd547,   16'd563,   16'd65535, PAR_ODD},
    '{16'd987,   16'd1007,  16'd65535, PAR_ODD},
    '{16'd1121,  16'd1153,  16'd65535, PAR_ODD},
    '{16'd1165,  16'd1215,  16'd65535, PAR_ODD},
    '{16'd1233,  16'd1269,  16'd65535, PAR_ODD},
    '{16'd7681,  16'd7829,  16'd65535, PAR_ODD},
    '{16'd7841,  16'd7929,  16'd65535, PAR_ODD},
    '{16'd8017,  16'd8023,  16'd8,     PAR_ODD}
  };

  localparam ucc_rule_t LoRules [LoRuleCnt] = '{
    '{16'd65,    16'd90,    16'd32,    PAR_ANY},
    '{16'd192,   16'd214,   16'd32,    PAR_ANY},
    '{16'd216,   16'd222,   16'd32,    PAR_ANY},
    '{16'd904,   16'd906,   16'd37,    PAR_ANY},
    '{16'd913,   16'd929,   16'd32,    PAR_ANY},
    '{16'd931,   16'd939,   16'd32,    PAR_ANY},
    '{16'd1024,  16'd1039,  16'd80,    PAR_ANY},
    '{16'd1040,  16'd1071,  16'd32,    PAR_ANY},
    '{16'd1329,  16'd1366,  16'd48,    PAR_ANY},
    '{16'd4256,  16'd4293,  16'd48,    PAR_ANY},
    '{16'd7944,  16'd7951,  16'd65528, PAR_ANY},
    '{16'd7960,  16'd7965,  16'd65528, PAR_ANY},
    '{16'd7976,  16'd7983,  16'd65528, PAR_ANY},
    '{16'd7992,  16'd7999,  16'd65528, PAR_ANY},
    '{16'd8008,  16'd8013,  16'd65528, PAR_ANY},
    '{16'd8040,  16'd8047,  16'd65528, PAR_ANY},
    '{16'd8072,  16'd8079,  16'd65528, PAR_ANY},
    '{16'd8088,  16'd8095,  16'd65528, PAR_ANY},
    '{16'd8104,  16'd8111,  16'd65528, PAR_ANY},
    '{16'd8136,  16'd8139,  16'd65450, PAR_ANY},
    '{16'd8544,  16'd8559,  16'd16,    PAR_ANY},
    '{16'd9398,  16'd9423,  16'd26,    PAR_ANY},
    '{16'd65313, 16'd65338, 16'd32,    PAR_ANY},
    '{16'd256,   16'd302,   16'd1,     PAR_EVEN},
    '{16'd306,   16'd310,   16'd1,     PAR_EVEN},
    '{16'd330,   16'd374,   16'd1,     PAR_EVEN},
    '{16'd386,   16'd388,   16'd1,     PAR_EVEN},
    '{16'd416,   16'd420,   16'd1,     PAR_EVEN},
    '{16'd478,   16'd494,   16'd1,     PAR_EVEN},
    '{16'd498,   16'd500,   16'd1,     PAR_EVEN},
    '{16'd504,   16'd542,   16'd1,     PAR_EVEN},
    '{16'd546,   16'd562,   16'd1,     PAR_EVEN},
    '{16'd986,   16'd1006,  16'd1,     PAR_EVEN},
    '{16'd1120,  16'd1152,  16'd1,     PAR_EVEN},
    '{16'd1164,  16'd1214,  16'd1,     PAR_EVEN},
    '{16'd1232,  16'd1268,  16'd1,     PAR_EVEN},
    '{16'd7680,  16'd7828,  16'd1,     PAR_EVEN},
    '{16'd7840,  16'd7928,  16'd1,     PAR_EVEN},
    '{16'd313,   16'd327,   16'd1,     PAR_ODD},
    '{16'd377,   16'd381,   16'd1,     PAR_ODD},
    '{16'd435,   16'd437,   16'd1,     PAR_ODD},
    '{16'd459,   16'd475,   16'd1,     PAR_ODD},
    '{16'd1217,  16'd1219,  16'd1,     PAR_ODD},
    '{16'd8025,  16'd8031,  16'd65528, PAR_ODD}
  };

  localparam ucc_pair_t UpMap [UpMapCnt] = '{
    '{16'd181, 16'd924},   '{16'd255, 16'd376},   '{16'd305, 16'd73},
    '{16'd383, 16'd83},    '{16'd392, 16'd391},   '{16'd396, 16'd395},
    '{16'd402, 16'd401},   '{16'd405, 16'd502},   '{16'd409, 16'd408},
    '{16'd424, 16'd423},   '{16'd429, 16'd428},   '{16'd432, 16'd431},
    '{16'd441, 16'd440},   '{16'd445, 16'd444},   '{16'd447, 16'd503},
    '{16'd453, 16'd452},   '{16'd454, 16'd452},   '{16'd456, 16'd455},
    '{16'd457, 16'd455},   '{16'd459, 16'd458},   '{16'd460, 16'd458},
    '{16'd477, 16'd398},   '{16'd498, 16'd497},   '{16'd499, 16'd497},
    '{16'd501, 16'd500},   '{16'd595, 16'd385},   '{16'd596, 16'd390},
    '{16'd598, 16'd393},   '{16'd599, 16'd394},   '{16'd601, 16'd399},
    '{16'd603, 16'd400},   '{16'd608, 16'd403},   '{16'd611, 16'd404},
    '{16'd616, 16'd407},   '{16'd617, 16'd406},   '{16'd623, 16'd412},
    '{16'd626, 16'd413},   '{16'd629, 16'd415},   '{16'd640, 16'd422},
    '{16'd643, 16'd425},   '{16'd648, 16'd430},   '{16'd650, 16'd433},
    '{16'd651, 16'd434},   '{16'd658, 16'd439},   '{16'd837, 16'd921},
    '{16'd940, 16'd902},   '{16'd962, 16'd931},   '{16'd972, 16'd908},
    '{16'd973, 16'd910},   '{16'd974, 16'd911},   '{16'd976, 16'd914},
    '{16'd977, 16'd920},   '{16'd981, 16'd934},   '{16'd982, 16'd928},
    '{16'd1008, 16'd922},  '{16'd1009, 16'd929},  '{16'd1010, 16'd931},
    '{16'd1013, 16'd917},  '{16'd1224, 16'd1223}, '{16'd1228, 16'd1227},
    '{16'd1273, 16'd1272}, '{16'd7835, 16'd7776}, '{16'd8048, 16'd8122},
    '{16'd8049, 16'd8123}, '{16'd8054, 16'd8154}, '{16'd8055, 16'd8155},
    '{16'd8056, 16'd8184}, '{16'd8057, 16'd8185}, '{16'd8058, 16'd8170},
    '{16'd8059, 16'd8171}, '{16'd8060, 16'd8186}, '{16'd8061, 16'd8187},
    '{16'd8112, 16'd8120}, '{16'd8113, 16'd8121}, '{16'd8115, 16'd8124},
    '{16'd8126, 16'd921},  '{16'd8131, 16'd8140}, '{16'd8144, 16'd8152},
    '{16'd8145, 16'd8153}, '{16'd8160, 16'd8168}, '{16'd8161, 16'd8169},
    '{16'd8165, 16'd8172}, '{16'd8179, 16'd8188}
  };

  localparam ucc_pair_t LoMap [LoMapCnt] = '{
    '{16'd304, 16'd105},   '{16'd376, 16'd255},   '{16'd385, 16'd595},
    '{16'd390, 16'd596},   '{16'd391, 16'd392},   '{16'd393, 16'd598},
    '{16'd394, 16'd599},   '{16'd395, 16'd396},   '{16'd398, 16'd477},
    '{16'd399, 16'd601},   '{16'd400, 16'd603},   '{16'd401, 16'd402},
    '{16'd403, 16'd608},   '{16'd404, 16'd611},   '{16'd406, 16'd617},
    '{16'd407, 16'd616},   '{16'd408, 16'd409},   '{16'd412, 16'd623},
    '{16'd413, 16'd626},   '{16'd415, 16'd629},   '{16'd422, 16'd640},
    '{16'd423, 16'd424},   '{16'd425, 16'd643},   '{16'd428, 16'd429},
    '{16'd430, 16'd648},   '{16'd431, 16'd432},   '{16'd433, 16'd650},
    '{16'd434, 16'd651},   '{16'd439, 16'd658},   '{16'd440, 16'd441},
    '{16'd444, 16'd445},   '{16'd452, 16'd454},   '{16'd453, 16'd454},
    '{16'd455, 16'd457},   '{16'd456, 16'd457},   '{16'd458, 16'd460},
    '{16'd497, 16'd499},   '{16'd502, 16'd405},   '{16'd503, 16'd447},
    '{16'd902, 16'd940},   '{16'd908, 16'd972},   '{16'd910, 16'd973},
    '{16'd911, 16'd974},   '{16'd1012, 16'd952},  '{16'd1223, 16'd1224},
    '{16'd1227, 16'd1228}, '{16'd1272, 16'd1273}, '{16'd8120, 16'd8112},
    '{16'd8121, 16'd8113}, '{16'd8122, 16'd8048}, '{16'd8123, 16'd8049},
    '{16'd8124, 16'd8115}, '{16'd8140, 16'd8131}, '{16'd8152, 16'd8144},
    '{16'd8153, 16'd8145}, '{16'd8154, 16'd8054}, '{16'd8155, 16'd8055},
    '{16'd8168, 16'd8160}, '{16'd8169, 16'd8161}, '{16'd8170, 16'd8058},
    '{16'd8171, 16'd8059}, '{16'd8172, 16'd8165}, '{16'd8184, 16'd8056},
    '{16'd8185, 16'd8057}, '{16'd8186, 16'd8060}, '{16'd8187, 16'd8061},
    '{16'd8188, 16'd8179}, '{16'd8486, 16'd969},  '{16'd8490, 16'd107},
    '{16'd8491, 16'd229}
  };

endpackage

### hdl/ucc_if.sv
// ucc_if: valid/ready stream interfaces for the case converter's input and result channels.
// Depends on ucc_pkg for the code unit type.
interface ucc_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  ucc_pkg::ucc_code_t code_unit;

  modport source (output valid, output mode, output code_unit, input ready);
  modport sink   (input valid, input mode, input code_unit, output ready);
endinterface

interface ucc_out_if;
  logic               valid;
  logic               ready;
  ucc_pkg::ucc_code_t converted;

  modport source (output valid, output converted, input ready);
  modport sink   (input valid, input converted, output ready);
endinterface

### hdl/ucc_mapper.sv
// ucc_mapper: combinational simple case mapping of one code unit, first matching rule wins.
// Depends on ucc_pkg for the rule and exception tables.
module ucc_mapper (
  input  logic               mode_i,
  input  ucc_pkg::ucc_code_t code_i,
  output ucc_pkg::ucc_code_t converted_o
);

  ucc_pkg::ucc_par_e  want;
  ucc_pkg::ucc_code_t up_res;
  ucc_pkg::ucc_code_t lo_res;

  assign want = code_i[0] ? ucc_pkg::PAR_ODD : ucc_pkg::PAR_EVEN;

  function automatic ucc_pkg::ucc_code_t apply_rule(input ucc_pkg::ucc_code_t c,
                                                    input ucc_pkg::ucc_code_t add);
    apply_rule = c + add;
  endfunction

  always_comb begin
    logic hit;
    hit    = 1'b0;
    up_res = code_i;
    for (int i = 0; i < ucc_pkg::UpRuleCnt; i++) begin
      if (!hit && code_i >= ucc_pkg::UpRules[i].lo && code_i <= ucc_pkg::UpRules[i].hi &&
          (ucc_pkg::UpRules[i].par == ucc_pkg::PAR_ANY || ucc_pkg::UpRules[i].par == want)) begin
        hit    = 1'b1;
        up_res = apply_rule(code_i, ucc_pkg::UpRules[i].add);
      end
    end
    for (int i = 0; i < ucc_pkg::UpMapCnt; i++) begin
      if (!hit && code_i == ucc_pkg::UpMap[i].src) begin
        hit    = 1'b1;
        up_res = ucc_pkg::UpMap[i].dst;
      end
    end
  end

  always_comb begin
    logic hit;
    hit    = 1'b0;
    lo_res = code_i;
    for (int i = 0; i < ucc_pkg::LoRuleCnt; i++) begin
      if (!hit && code_i >= ucc_pkg::LoRules[i].lo && code_i <= ucc_pkg::LoRules[i].hi &&
          (ucc_pkg::LoRules[i].par == ucc_pkg::PAR_ANY || ucc_pkg::LoRules[i].par == want)) begin
        hit    = 1'b1;
        lo_res = apply_rule(code_i, ucc_pkg::LoRules[i].add);
      end
    end
    for (int i = 0; i < ucc_pkg::LoMapCnt; i++) begin
      if (!hit && code_i == ucc_pkg::LoMap[i].src) begin
        hit    = 1'b1;
        lo_res = ucc_pkg::LoMap[i].dst;
      end
    end
  end

  assign converted_o = mode_i ? lo_res : up_res;

endmodule

### hdl/utf16_case_converter.sv
// utf16_case_converter: top level, input register, case mapper and result register.
// Depends on ucc_pkg, ucc_if.sv (ucc_in_if, ucc_out_if) and ucc_mapper.
//
// Usage:
//   in_i  (ucc_in_if.sink)    one transaction per code unit: mode (0 upper, 1 lower)
//                             and code_unit.
//   out_o (ucc_out_if.source) one transaction per accepted input: converted.
//   Results leave in the order the inputs arrived, exactly one per input.
//   Path: a code unit accepted on in_i passes through the input register, then the mapping
//   logic, then the result register, before its result shows on out_o.
//   Throughput: one transaction per cycle while out_o.ready is high, set by the
//   combinational mapping path between the two registers.
//   Stall: while out_o.ready is low the result register holds; the input register
//   still takes one more item, after which in_i.ready goes low until the result
//   register drains. in_i.ready depends combinationally on out_o.ready.
//   Reset (rst_ni low, asynchronous): both stages empty, out_o.valid low,
//   in_i.ready high. There is no configuration and no state between items.
module utf16_case_converter (
  input  logic            clk_i,
  input  logic            rst_ni,
  ucc_in_if.sink          in_i,
  ucc_out_if.source       out_o
);

  logic               s1_valid_q;
  logic               s1_mode_q;
  ucc_pkg::ucc_code_t s1_code_q;
  logic               out_valid_q;
  ucc_pkg::ucc_code_t out_conv_q;
  ucc_pkg::ucc_code_t mapped;
  logic               out_adv;
  logic               in_take;

  assign out_adv    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_adv;
  assign in_take    = in_i.valid && in_i.ready;

  ucc_mapper u_mapper (
    .mode_i      (s1_mode_q),
    .code_i      (s1_code_q),
    .converted_o (mapped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_mode_q <= in_i.mode;
      s1_code_q <= in_i.code_unit;
    end
    if (out_adv && s1_valid_q) begin
      out_conv_q <= mapped;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.converted = out_conv_q;

  a_take_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted transaction not captured in input stage");

  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_adv) |=> (s1_valid_q && $stable(s1_code_q) && $stable(s1_mode_q)))
    else $error("input stage lost or changed a transaction under stall");

  a_result_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_adv) |=> (out_valid_q && out_conv_q == $past(mapped)))
    else $error("result register did not take the mapped code");

  a_ready_low_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled while pipeline has room");

endmodule
